FILE: hw/rtl/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

    localparam int LED_LANES_DEF  = 4;
    localparam int COUNT_BITS_DEF = 12;
    localparam int COUNT_BITS_MAX = 16;
    localparam int OUT_LEVELS     = 4;
    localparam int LEVEL_W        = 15;
    localparam int POS_W          = COUNT_BITS_MAX + 6;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [7:0] PEAK_RST  = 8'd150;
    localparam logic [5:0] PHASE_RST = 6'd30;
    localparam logic [3:0] FADE_RST  = 4'd5;
    localparam logic [7:0] DELAY_RST = 8'd40;

    localparam logic [1:0] REG_PEAK  = 2'd0;
    localparam logic [1:0] REG_PHASE = 2'd1;
    localparam logic [1:0] REG_FADE  = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    typedef enum logic [1:0] {
        ACT_RUN   = 2'd0,
        ACT_ABORT = 2'd1,
        ACT_SLEEP = 2'd2,
        ACT_SHIP  = 2'd3
    } action_t;

    typedef struct packed {
        logic [7:0] peak;
        logic [5:0] phase;
        logic [3:0] fade;
        logic [7:0] delay;
    } cfg_t;

    typedef struct packed {
        logic                    started;
        logic signed [POS_W-1:0] pos;
        logic [5:0]              ph;
    } ramp_t;

    typedef logic [LEVEL_W-1:0] gamma_rom_t [256];

    // entry v is the largest g with g^5 <= v^9
    function automatic gamma_rom_t gamma_build();
        gamma_rom_t       rom;
        logic [127:0]     p9;
        logic [127:0]     p5;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] t;
        int               v;
        int               k;
        int               b;
        for (v = 0; v < 256; v++) begin
            p9 = 128'd1;
            for (k = 0; k < 9; k++) begin
                p9 = p9 * 128'(v);
            end
            g = '0;
            for (b = LEVEL_W - 1; b >= 0; b--) begin
                t = g | (LEVEL_W'(1) << b);
                p5 = 128'd1;
                for (k = 0; k < 5; k++) begin
                    p5 = p5 * 128'(t);
                end
                if (p5 <= p9) begin
                    g = t;
                end
            end
            rom[v] = g;
        end
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = gamma_build();

endpackage

FILE: hw/rtl/lfs_ramp.sv
`timescale 1ns / 1ps

module lfs_ramp #(
    parameter int COUNT_BITS = lfs_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] tick_count,
    input  lfs_pkg::cfg_t         cfg,
    output lfs_pkg::ramp_t        ramp_out
);

    logic [COUNT_BITS-1:0] delay_ext;
    logic [COUNT_BITS-1:0] ramp;
    logic [8:0]            total;
    logic [COUNT_BITS-1:0] total_ext;
    logic                  fade_out;
    logic [COUNT_BITS-1:0] over;
    logic [COUNT_BITS+3:0] prod;

    assign delay_ext = COUNT_BITS'(cfg.delay);
    assign ramp      = (tick_count >= delay_ext) ? (tick_count - delay_ext) : '0;
    assign total     = 9'(cfg.peak) + 9'({cfg.phase, 1'b0}) + 9'(cfg.phase);
    assign total_ext = COUNT_BITS'(total);
    assign fade_out  = (ramp >= total_ext);
    assign over      = ramp - total_ext;
    assign prod      = (COUNT_BITS+4)'(over) * (COUNT_BITS+4)'(cfg.fade);

    always_comb begin
        ramp_out.started = (ramp != '0);
        if (fade_out) begin
            ramp_out.pos = signed'(lfs_pkg::POS_W'(total)) - signed'(lfs_pkg::POS_W'(prod));
            ramp_out.ph  = '0;
        end else begin
            ramp_out.pos = signed'(lfs_pkg::POS_W'(ramp));
            ramp_out.ph  = cfg.phase;
        end
    end

endmodule

FILE: hw/rtl/lfs_lane.sv
`timescale 1ns / 1ps

module lfs_lane #(
    parameter int LANE_IDX = 0
) (
    input  lfs_pkg::ramp_t                ramp_in,
    input  logic [7:0]                    peak,
    output logic [lfs_pkg::LEVEL_W-1:0]   level,
    output logic                          is_zero
);

    logic [8:0]                       offset;
    logic signed [lfs_pkg::POS_W-1:0] v;
    logic [7:0]                       v_clamp;

    assign offset = 9'(ramp_in.ph) * 9'(LANE_IDX);
    assign v      = ramp_in.pos - signed'(lfs_pkg::POS_W'(offset));

    always_comb begin
        if (v < 0) begin
            v_clamp = '0;
        end else if (v > signed'(lfs_pkg::POS_W'(peak))) begin
            v_clamp = peak;
        end else begin
            v_clamp = v[7:0];
        end
    end

    // gamma of zero is the only zero entry
    assign is_zero = (v_clamp == '0);
    assign level   = lfs_pkg::GAMMA_ROM[v_clamp];

endmodule

FILE: hw/rtl/long_press_led_fade_sequencer.sv
`timescale 1ns / 1ps

// Long-press LED fade sequencer. Each transfer on the s_ channel is one button
// sample tick and yields exactly one transfer on the m_ channel carrying four
// gamma-corrected LED levels and an action code (run, abort, sleep, shipping).
// One tick is accepted every clock cycle unless a stalled result blocks it. A
// tick lands in the input register at its transfer; ramp multiply and gamma
// lookup feed the m_ output register, which takes each result when free. A
// stalled result blocks s_ready only once the input register also holds a tick.
// Registers are written through the APB port at byte offsets 0x0 peak,
// 0x4 phase step, 0x8 fade speed, 0xC start delay, and should be changed only
// while no tick is in flight.
module long_press_led_fade_sequencer #(
    parameter int LED_LANES  = lfs_pkg::LED_LANES_DEF,
    parameter int COUNT_BITS = lfs_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_hold_pressed,
    input  logic                          s_up_pressed,
    input  logic                          s_down_pressed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lfs_pkg::LEVEL_W-1:0]   m_led_level_0,
    output logic [lfs_pkg::LEVEL_W-1:0]   m_led_level_1,
    output logic [lfs_pkg::LEVEL_W-1:0]   m_led_level_2,
    output logic [lfs_pkg::LEVEL_W-1:0]   m_led_level_3,
    output logic [1:0]                    m_action,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [lfs_pkg::DATA_W-1:0]    pwdata,
    output logic [lfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    lfs_pkg::cfg_t cfg_reg;
    logic          cfg_wr;

    logic in_valid_reg, in_valid_next;
    logic hold_reg, up_reg, down_reg;
    logic adv, s_xfer;

    logic [COUNT_BITS-1:0] tick_count_reg, tick_count_next;

    logic                        m_valid_reg, m_valid_next;
    logic [lfs_pkg::LEVEL_W-1:0] level_reg [lfs_pkg::OUT_LEVELS];
    logic [lfs_pkg::LEVEL_W-1:0] level_next [lfs_pkg::OUT_LEVELS];
    lfs_pkg::action_t            action_reg, action_next;

    lfs_pkg::ramp_t              ramp;
    logic [lfs_pkg::LEVEL_W-1:0] lane_level [LED_LANES];
    logic [LED_LANES-1:0]        lane_zero;
    logic [lfs_pkg::LEVEL_W-1:0] out_level [lfs_pkg::OUT_LEVELS];
    logic                        terminal;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak  <= lfs_pkg::PEAK_RST;
            cfg_reg.phase <= lfs_pkg::PHASE_RST;
            cfg_reg.fade  <= lfs_pkg::FADE_RST;
            cfg_reg.delay <= lfs_pkg::DELAY_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lfs_pkg::REG_PEAK:  cfg_reg.peak  <= pwdata[7:0];
                lfs_pkg::REG_PHASE: cfg_reg.phase <= pwdata[5:0];
                lfs_pkg::REG_FADE:  cfg_reg.fade  <= pwdata[3:0];
                lfs_pkg::REG_DELAY: cfg_reg.delay <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lfs_pkg::REG_PEAK:  prdata = lfs_pkg::DATA_W'(cfg_reg.peak);
            lfs_pkg::REG_PHASE: prdata = lfs_pkg::DATA_W'(cfg_reg.phase);
            lfs_pkg::REG_FADE:  prdata = lfs_pkg::DATA_W'(cfg_reg.fade);
            lfs_pkg::REG_DELAY: prdata = lfs_pkg::DATA_W'(cfg_reg.delay);
            default:            prdata = '0;
        endcase
    end

    // handshake
    assign adv     = in_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | adv;
    assign s_xfer  = s_valid & s_ready;

    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            hold_reg <= s_hold_pressed;
            up_reg   <= s_up_pressed;
            down_reg <= s_down_pressed;
        end
    end

    // datapath
    lfs_ramp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ramp (
        .tick_count (tick_count_reg),
        .cfg        (cfg_reg),
        .ramp_out   (ramp)
    );

    for (genvar i = 0; i < LED_LANES; i++) begin : g_lane
        lfs_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .ramp_in (ramp),
            .peak    (cfg_reg.peak),
            .level   (lane_level[i]),
            .is_zero (lane_zero[i])
        );
    end

    for (genvar j = 0; j < lfs_pkg::OUT_LEVELS; j++) begin : g_out
        if (j < LED_LANES) begin : g_used
            assign out_level[j] = lane_level[j];
        end else begin : g_unused
            assign out_level[j] = '0;
        end
    end

    assign terminal = ramp.started & (&lane_zero);

    always_comb begin
        tick_count_next = tick_count_reg;
        for (int j = 0; j < lfs_pkg::OUT_LEVELS; j++) begin
            level_next[j] = out_level[j];
        end
        if (!hold_reg) begin
            for (int j = 0; j < lfs_pkg::OUT_LEVELS; j++) begin
                level_next[j] = '0;
            end
            action_next     = lfs_pkg::ACT_ABORT;
            tick_count_next = '0;
        end else if (terminal) begin
            action_next     = (up_reg & down_reg) ? lfs_pkg::ACT_SHIP : lfs_pkg::ACT_SLEEP;
            tick_count_next = '0;
        end else begin
            action_next = lfs_pkg::ACT_RUN;
            if (tick_count_reg != '1) begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else if (adv) begin
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < lfs_pkg::OUT_LEVELS; j++) begin
                level_reg[j] <= level_next[j];
            end
            action_reg <= action_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_level_0 = level_reg[0];
    assign m_led_level_1 = level_reg[1];
    assign m_led_level_2 = level_reg[2];
    assign m_led_level_3 = level_reg[3];
    assign m_action      = action_reg;

    // checks
    a_abort_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !hold_reg) |=> (tick_count_reg == '0))
        else $error("abort did not clear tick counter");

    a_terminal_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action == lfs_pkg::ACT_SLEEP || m_action == lfs_pkg::ACT_SHIP))
        |-> (m_led_level_0 == '0 && m_led_level_1 == '0 &&
             m_led_level_2 == '0 && m_led_level_3 == '0))
        else $error("terminal report with lit LED");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_count_reg != '0) |->
        (tick_count_reg == $past(tick_count_reg) ||
         tick_count_reg == $past(tick_count_reg) + 1'b1))
        else $error("tick counter jumped");

    a_out_hold_while_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> (!adv ##1 m_valid))
        else $error("result overwritten while stalled");

endmodule

FILE: test/tb_long_press_led_fade_sequencer.sv
`timescale 1ns / 1ps

module tb_long_press_led_fade_sequencer;

    localparam int LANES   = 4;
    localparam int CNT_W   = 12;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    typedef struct packed {
        logic hold;
        logic up;
        logic down;
    } button_tick_t;

    typedef struct packed {
        logic [lfs_pkg::OUT_LEVELS-1:0][lfs_pkg::LEVEL_W-1:0] lvl;
        lfs_pkg::action_t                                     act;
    } led_frame_t;

    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         s_valid        = 1'b0;
    wire                          s_ready;
    logic                         s_hold_pressed = 1'b0;
    logic                         s_up_pressed   = 1'b0;
    logic                         s_down_pressed = 1'b0;
    wire                          m_valid;
    logic                         m_ready        = 1'b0;
    wire [lfs_pkg::LEVEL_W-1:0]   m_led_level_0;
    wire [lfs_pkg::LEVEL_W-1:0]   m_led_level_1;
    wire [lfs_pkg::LEVEL_W-1:0]   m_led_level_2;
    wire [lfs_pkg::LEVEL_W-1:0]   m_led_level_3;
    wire [1:0]                    m_action;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [lfs_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [lfs_pkg::DATA_W-1:0]   pwdata         = '0;
    wire [lfs_pkg::DATA_W-1:0]    prdata;
    wire                          pready;

    long_press_led_fade_sequencer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_hold_pressed (s_hold_pressed),
        .s_up_pressed   (s_up_pressed),
        .s_down_pressed (s_down_pressed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_level_0  (m_led_level_0),
        .m_led_level_1  (m_led_level_1),
        .m_led_level_2  (m_led_level_2),
        .m_led_level_3  (m_led_level_3),
        .m_action       (m_action),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [lfs_pkg::LEVEL_W-1:0] gamma_lut [256];
    logic [7:0]                  cfg_peak;
    logic [5:0]                  cfg_phase;
    logic [3:0]                  cfg_fade;
    logic [7:0]                  cfg_delay;
    logic [CNT_W-1:0]            hold_ticks;

    button_tick_t tick_queue [$];
    led_frame_t   pending_frames [$];

    int ticks_sent     = 0;
    int ticks_accepted = 0;
    int phase_items    = 0;
    int mismatches     = 0;
    int reg_writes     = 0;
    int n_abort        = 0;
    int n_sleep        = 0;
    int n_ship         = 0;
    int n_saturated    = 0;

    int in_gap    = 0;
    bit in_burst  = 1'b0;
    int out_stall = 0;
    bit out_burst = 1'b0;

    function automatic logic [127:0] ipow(input int base, input int e);
        logic [127:0] p;
        int           k;
        p = 128'd1;
        for (k = 0; k < e; k++) begin
            p = p * 128'(base);
        end
        return p;
    endfunction

    // largest g with g^5 <= v^9
    task automatic build_gamma();
        logic [127:0] p9;
        int           g;
        int           v;
        g = 0;
        for (v = 0; v < 256; v++) begin
            p9 = ipow(v, 9);
            while (g < 32767 && ipow(g + 1, 5) <= p9) begin
                g++;
            end
            gamma_lut[v] = lfs_pkg::LEVEL_W'(g);
        end
    endtask

    function automatic led_frame_t predict_frame(input button_tick_t t);
        led_frame_t f;
        int         ramp;
        int         total;
        int         pos;
        int         ph;
        int         v;
        int         sum;
        int         i;
        f = '0;
        if (!t.hold) begin
            f.act      = lfs_pkg::ACT_ABORT;
            hold_ticks = '0;
            return f;
        end
        ramp  = (int'(hold_ticks) < int'(cfg_delay)) ? 0 : int'(hold_ticks) - int'(cfg_delay);
        total = int'(cfg_peak) + 3 * int'(cfg_phase);
        if (ramp >= total) begin
            pos = total - (ramp - total) * int'(cfg_fade);
            ph  = 0;
        end else begin
            pos = ramp;
            ph  = int'(cfg_phase);
        end
        sum = 0;
        for (i = 0; i < LANES; i++) begin
            v = pos - i * ph;
            if (v < 0) begin
                v = 0;
            end
            if (v > int'(cfg_peak)) begin
                v = int'(cfg_peak);
            end
            f.lvl[i] = gamma_lut[v];
            sum += int'(gamma_lut[v]);
        end
        if (ramp > 0 && sum == 0) begin
            f.act      = (t.up && t.down) ? lfs_pkg::ACT_SHIP : lfs_pkg::ACT_SLEEP;
            hold_ticks = '0;
        end else begin
            f.act = lfs_pkg::ACT_RUN;
            if (int'(hold_ticks) < CNT_MAX) begin
                hold_ticks++;
            end
        end
        return f;
    endfunction

    always @(posedge aclk) begin : driver
        button_tick_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (in_gap != 0) begin
                s_valid <= 1'b0;
                in_gap--;
            end else if (tick_queue.size() != 0) begin
                t = tick_queue.pop_front();
                s_valid        <= 1'b1;
                s_hold_pressed <= t.hold;
                s_up_pressed   <= t.up;
                s_down_pressed <= t.down;
                if ($urandom_range(0, 39) == 0) begin
                    in_burst = !in_burst;
                end
                in_gap = in_burst ? 0 : $urandom_range(0, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        button_tick_t t;
        led_frame_t   f;
        led_frame_t   exp_f;
        led_frame_t   got;
        bit           bad;
        int           i;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                t.hold = s_hold_pressed;
                t.up   = s_up_pressed;
                t.down = s_down_pressed;
                if (t.hold && int'(hold_ticks) == CNT_MAX) begin
                    n_saturated++;
                end
                f = predict_frame(t);
                case (f.act)
                    lfs_pkg::ACT_ABORT: n_abort++;
                    lfs_pkg::ACT_SLEEP: n_sleep++;
                    lfs_pkg::ACT_SHIP:  n_ship++;
                    default: ;
                endcase
                pending_frames.push_back(f);
                ticks_accepted++;
            end
            if (m_valid && m_ready) begin
                got.lvl[0] = m_led_level_0;
                got.lvl[1] = m_led_level_1;
                got.lvl[2] = m_led_level_2;
                got.lvl[3] = m_led_level_3;
                got.act    = lfs_pkg::action_t'(m_action);
                if (pending_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transfer with nothing expected: %0d %0d %0d %0d",
                                 $time, got.lvl[0], got.lvl[1], got.lvl[2], got.lvl[3],
                                 " act %0d", got.act);
                    end
                end else begin
                    exp_f = pending_frames.pop_front();
                    bad   = 1'b0;
                    for (i = 0; i < lfs_pkg::OUT_LEVELS; i++) begin
                        if (got.lvl[i] !== exp_f.lvl[i]) begin
                            bad = 1'b1;
                        end
                    end
                    if (got.act !== exp_f.act) begin
                        bad = 1'b1;
                    end
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp %0d %0d %0d %0d act %0d,",
                                     $time, exp_f.lvl[0], exp_f.lvl[1], exp_f.lvl[2],
                                     exp_f.lvl[3], exp_f.act,
                                     " got %0d %0d %0d %0d act %0d",
                                     got.lvl[0], got.lvl[1], got.lvl[2], got.lvl[3],
                                     got.act);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    out_burst = !out_burst;
                end
                out_stall = out_burst ? 0 : $urandom_range(0, 12);
            end
            if (out_stall != 0) begin
                m_ready <= 1'b0;
                out_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        @(posedge aclk);
        while (ticks_accepted != ticks_sent || pending_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        logic [lfs_pkg::DATA_W-1:0] data;
        logic [lfs_pkg::DATA_W-1:0] rd_exp;
        data = $urandom;
        case (idx)
            lfs_pkg::REG_PHASE: data[5:0] = val[5:0];
            lfs_pkg::REG_FADE:  data[3:0] = val[3:0];
            default:            data[7:0] = val;
        endcase
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lfs_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        // read the register back at the same address
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // upper bits are dropped by the register width
        case (idx)
            lfs_pkg::REG_PEAK: begin
                cfg_peak = data[7:0];
                rd_exp   = lfs_pkg::DATA_W'(data[7:0]);
            end
            lfs_pkg::REG_PHASE: begin
                cfg_phase = data[5:0];
                rd_exp    = lfs_pkg::DATA_W'(data[5:0]);
            end
            lfs_pkg::REG_FADE: begin
                cfg_fade = data[3:0];
                rd_exp   = lfs_pkg::DATA_W'(data[3:0]);
            end
            default: begin
                cfg_delay = data[7:0];
                rd_exp    = lfs_pkg::DATA_W'(data[7:0]);
            end
        endcase
        reg_writes++;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (prdata !== rd_exp) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: register %0d read %0h, expected %0h",
                         $time, idx, prdata, rd_exp);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] peak, input logic [5:0] phase,
                              input logic [3:0] fade, input logic [7:0] delay);
        wait_idle();
        cfg_write(lfs_pkg::REG_PEAK, peak);
        cfg_write(lfs_pkg::REG_PHASE, {2'b00, phase});
        cfg_write(lfs_pkg::REG_FADE, {4'b0000, fade});
        cfg_write(lfs_pkg::REG_DELAY, delay);
        phase_items = 0;
    endtask

    task automatic push_tick(input logic h, input logic u, input logic d);
        button_tick_t t;
        t.hold = h;
        t.up   = u;
        t.down = d;
        tick_queue.push_back(t);
        ticks_sent++;
        phase_items++;
    endtask

    task automatic hold_sequence(input int len);
        int   mode;
        int   i;
        logic u;
        logic d;
        mode = $urandom_range(0, 2);
        for (i = 0; i < len; i++) begin
            case (mode)
                0: begin
                    u = 1'($urandom);
                    d = 1'($urandom);
                end
                1: begin
                    u = 1'b1;
                    d = 1'b1;
                end
                default: begin
                    u = 1'b0;
                    d = 1'($urandom);
                end
            endcase
            push_tick(1'b1, u, d);
        end
    endtask

    task automatic run_sequence();
        int total;
        int est;
        int r;
        total = int'(cfg_peak) + 3 * int'(cfg_phase);
        if (cfg_fade == 0) begin
            est = int'(cfg_delay) + total + 40;
        end else begin
            est = int'(cfg_delay) + total + (total + int'(cfg_fade) - 1) / int'(cfg_fade) + 1;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            hold_sequence(est + $urandom_range(0, 4));
        end else if (r < 85) begin
            hold_sequence($urandom_range(1, est));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                push_tick(1'($urandom), 1'($urandom), 1'($urandom));
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            push_tick(1'b0, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_phase(input int budget);
        while (phase_items < budget) begin
            run_sequence();
        end
    endtask

    initial begin : main
        int i;
        int drain;
        build_gamma();
        cfg_peak   = 8'd150;
        cfg_phase  = 6'd30;
        cfg_fade   = 4'd5;
        cfg_delay  = 8'd40;
        hold_ticks = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // release at reset settings
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0);

        // zero peak: first tick past the delay ends the ramp
        set_config(8'd0, 6'd0, 4'd1, 8'd0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0);

        // short full ramp with fast fade-out
        set_config(8'd2, 6'd1, 4'd15, 8'd1);
        repeat (7) push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);

        set_config(8'd150, 6'd30, 4'd5, 8'd40);
        random_phase(200);
        set_config(8'd255, 6'd63, 4'd15, 8'd255);
        random_phase(300);
        set_config(8'd1, 6'd0, 4'd1, 8'd0);
        random_phase(60);

        // zero fade speed: levels hold once the fade-in total is reached
        set_config(8'($urandom_range(1, 100)), 6'($urandom_range(0, 20)), 4'd0,
                   8'($urandom_range(0, 40)));
        hold_sequence(260);
        push_tick(1'b0, 1'($urandom), 1'($urandom));

        for (i = 0; i < 6; i++) begin
            set_config(8'($urandom_range(0, 48)), 6'($urandom_range(0, 12)),
                       4'($urandom_range(1, 15)), 8'($urandom_range(0, 24)));
            random_phase(40);
        end

        @(posedge aclk);
        while (ticks_accepted != ticks_sent) begin
            @(posedge aclk);
        end
        drain = 0;
        while (pending_frames.size() != 0 && drain < 2000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        if (pending_frames.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_frames.size());
        end

        $display("%0d ticks checked across %0d register writes, %0d mismatches",
                 ticks_accepted, reg_writes, mismatches);
        $display("terminal reports: %0d aborts, %0d sleep, %0d shipping; %0d saturated ticks",
                 n_abort, n_sleep, n_ship, n_saturated);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: long_press_led_fade_sequencer.f
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_ramp.sv
hw/rtl/lfs_lane.sv
hw/rtl/long_press_led_fade_sequencer.sv
test/tb_long_press_led_fade_sequencer.sv
